// ===== rtl/rdcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rdcs_pkg: shared types and constants for the ray column setup
// Holds the fixed field widths and the record that moves through the
// reciprocal cell chain.
// ----------------------------------------------------------------------------
package rdcs_pkg;

   localparam int RayWidth  = 19;
   localparam int MagWidth  = 19;
   localparam int RemWidth  = 19;
   localparam int QuoWidth  = 33;
   localparam int DistWidth = 32;
   localparam int CellCount = 33;

   localparam logic [2:0] CsrPositionX = 3'd0;
   localparam logic [2:0] CsrPositionY = 3'd1;
   localparam logic [2:0] CsrFacingX   = 3'd2;
   localparam logic [2:0] CsrFacingY   = 3'd3;
   localparam logic [2:0] CsrPlaneX    = 3'd4;
   localparam logic [2:0] CsrPlaneY    = 3'd5;

   typedef struct packed {
      logic                        valid;
      logic signed [RayWidth-1:0]  ray_x;
      logic signed [RayWidth-1:0]  ray_y;
      logic [MagWidth-1:0]         mag_x;
      logic [MagWidth-1:0]         mag_y;
      logic [RemWidth-1:0]         rem_x;
      logic [RemWidth-1:0]         rem_y;
      logic [QuoWidth-1:0]         quo_x;
      logic [QuoWidth-1:0]         quo_y;
   } cell_type;

endpackage

// ===== rtl/rdcs_cell.sv =====
// ----------------------------------------------------------------------------
// rdcs_cell: one restoring division step for both ray axes
// Shifts in one dividend bit, subtracts the magnitude when it fits and
// hands the record to the next cell.
// ----------------------------------------------------------------------------
module rdcs_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               dividend_bit,
   input  rdcs_pkg::cell_type cell_in,
   output rdcs_pkg::cell_type cell_out
);

   rdcs_pkg::cell_type         out_ff;
   rdcs_pkg::cell_type         out_in;
   logic [rdcs_pkg::RemWidth:0] trial_x;
   logic [rdcs_pkg::RemWidth:0] trial_y;
   logic                        fits_x;
   logic                        fits_y;

   always_comb begin
      trial_x = {cell_in.rem_x, dividend_bit};
      trial_y = {cell_in.rem_y, dividend_bit};
      fits_x  = trial_x >= {1'b0, cell_in.mag_x};
      fits_y  = trial_y >= {1'b0, cell_in.mag_y};
      out_in  = cell_in;
      out_in.rem_x = fits_x ? rdcs_pkg::RemWidth'(trial_x - {1'b0, cell_in.mag_x})
                            : rdcs_pkg::RemWidth'(trial_x);
      out_in.rem_y = fits_y ? rdcs_pkg::RemWidth'(trial_y - {1'b0, cell_in.mag_y})
                            : rdcs_pkg::RemWidth'(trial_y);
      out_in.quo_x = {cell_in.quo_x[rdcs_pkg::QuoWidth-2:0], fits_x};
      out_in.quo_y = {cell_in.quo_y[rdcs_pkg::QuoWidth-2:0], fits_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;

endmodule

// ===== rtl/raycast_dda_column_setup.sv =====
// ----------------------------------------------------------------------------
// raycast_dda_column_setup: grid DDA ray setup for one screen column
// Pipeline: an accepted request passes through 5 setup stages, 33
// reciprocal cells, the side stage and the output register to its result.
// Throughput: one request per cycle; the 33-cell reciprocal chain and the
// whole pipeline advance together whenever the result register can move.
// Reset: synchronous; clears all valid bits and the camera registers to zero.
// ----------------------------------------------------------------------------
module raycast_dda_column_setup #(
   parameter int SCREEN_WIDTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [9:0]  req_column,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [18:0] rsp_ray_x,
   output logic signed [18:0] rsp_ray_y,
   output logic [7:0]  rsp_cell_x,
   output logic [7:0]  rsp_cell_y,
   output logic        rsp_step_x_negative,
   output logic        rsp_step_y_negative,
   output logic [31:0] rsp_delta_x,
   output logic [31:0] rsp_delta_y,
   output logic [31:0] rsp_side_x,
   output logic [31:0] rsp_side_y
);

   // Camera offset is floor(col * 2^17 / W) - 2^16: multiply by a reciprocal
   // scaled by 2^10 (col < 2^10), then fix the single possible undershoot.
   localparam logic [26:0] RecipScale = 27'((64'd1 << 27) / SCREEN_WIDTH);
   localparam logic [39:0] WidthWide  = 40'(SCREEN_WIDTH);

   // camera registers
   logic [23:0]        position_x_ff, position_y_ff;
   logic signed [17:0] facing_x_ff, facing_y_ff, plane_x_ff, plane_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_x_ff <= '0;
         position_y_ff <= '0;
         facing_x_ff   <= '0;
         facing_y_ff   <= '0;
         plane_x_ff    <= '0;
         plane_y_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            rdcs_pkg::CsrPositionX: position_x_ff <= csr_data;
            rdcs_pkg::CsrPositionY: position_y_ff <= csr_data;
            rdcs_pkg::CsrFacingX:   facing_x_ff   <= csr_data[17:0];
            rdcs_pkg::CsrFacingY:   facing_y_ff   <= csr_data[17:0];
            rdcs_pkg::CsrPlaneX:    plane_x_ff    <= csr_data[17:0];
            rdcs_pkg::CsrPlaneY:    plane_y_ff    <= csr_data[17:0];
            default: ;
         endcase
      end
   end

   // Advance every stage together; the output register parts the sides.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   logic [5:0] stage_valid_ff;

   // stage 1: column times reciprocal
   logic [9:0]  col1_ff;
   logic [36:0] recip_prod_ff;
   // stage 2: estimate and its back product
   logic [9:0]  col2_ff;
   logic [26:0] est_ff;
   logic [39:0] back_prod_ff;
   // stage 3: camera offset
   logic signed [28:0] cam_ff;
   logic        quo_fix;
   // stage 4: plane times offset
   logic signed [46:0] plane_prod_x_ff, plane_prod_y_ff;
   // stage 5: saturated ray
   logic signed [18:0] ray_x_ff, ray_y_ff;
   logic signed [18:0] ray_x_in, ray_y_in;

   function automatic logic signed [18:0] ray_sat(input logic signed [17:0] dir,
                                                  input logic signed [46:0] prod);
      logic signed [31:0] sum;
      sum = 32'($signed(prod[46:16])) + 32'(dir);
      if (sum < -32'sd262144) begin
         return -19'sd262144;
      end else if (sum > 32'sd262143) begin
         return 19'sd262143;
      end
      return sum[18:0];
   endfunction

   assign quo_fix  = (40'({col2_ff, 17'd0}) - back_prod_ff) >= WidthWide;
   assign ray_x_in = ray_sat(facing_x_ff, plane_prod_x_ff);
   assign ray_y_in = ray_sat(facing_y_ff, plane_prod_y_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         col1_ff         <= req_column;
         recip_prod_ff   <= 37'(req_column) * 37'(RecipScale);
         col2_ff         <= col1_ff;
         est_ff          <= recip_prod_ff[36:10];
         back_prod_ff    <= 40'(recip_prod_ff[36:10]) * WidthWide;
         cam_ff          <= 29'(est_ff) + 29'(quo_fix) - 29'sd65536;
         plane_prod_x_ff <= plane_x_ff * cam_ff;
         plane_prod_y_ff <= plane_y_ff * cam_ff;
         ray_x_ff        <= ray_x_in;
         ray_y_ff        <= ray_y_in;
      end
   end

   // Reciprocal chain: 2^32 / |ray|, one quotient bit per cell.
   rdcs_pkg::cell_type chain [0:rdcs_pkg::CellCount];

   always_comb begin
      chain[0]       = '0;
      chain[0].valid = stage_valid_ff[4];
      chain[0].ray_x = ray_x_ff;
      chain[0].ray_y = ray_y_ff;
      chain[0].mag_x = ray_x_ff[18] ? 19'(-ray_x_ff) : 19'(ray_x_ff);
      chain[0].mag_y = ray_y_ff[18] ? 19'(-ray_y_ff) : 19'(ray_y_ff);
   end

   for (genvar k = 0; k < rdcs_pkg::CellCount; k++) begin : g_cell
      rdcs_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .dividend_bit (k == 0),
         .cell_in      (chain[k]),
         .cell_out     (chain[k+1])
      );
   end

   rdcs_pkg::cell_type last;
   assign last = chain[rdcs_pkg::CellCount];

   // stage 6: saturate delta and form f * delta
   logic [31:0] delta_x_in, delta_y_in, delta_x_ff, delta_y_ff;
   logic [16:0] frac_x, frac_y;
   logic [48:0] side_prod_x_ff, side_prod_y_ff;
   logic        f_zero_x_ff, f_zero_y_ff;
   logic signed [18:0] ray6_x_ff, ray6_y_ff;

   assign delta_x_in = last.quo_x[32] ? '1 : last.quo_x[31:0];
   assign delta_y_in = last.quo_y[32] ? '1 : last.quo_y[31:0];
   // Negative ray walks back to the cell's own edge, positive to the next.
   assign frac_x = last.ray_x[18] ? {1'b0, position_x_ff[15:0]}
                                  : 17'd65536 - {1'b0, position_x_ff[15:0]};
   assign frac_y = last.ray_y[18] ? {1'b0, position_y_ff[15:0]}
                                  : 17'd65536 - {1'b0, position_y_ff[15:0]};

   always_ff @(posedge clock) begin
      if (advance) begin
         delta_x_ff     <= delta_x_in;
         delta_y_ff     <= delta_y_in;
         side_prod_x_ff <= 49'(frac_x) * 49'(delta_x_in);
         side_prod_y_ff <= 49'(frac_y) * 49'(delta_y_in);
         f_zero_x_ff    <= frac_x == 17'd0;
         f_zero_y_ff    <= frac_y == 17'd0;
         ray6_x_ff      <= last.ray_x;
         ray6_y_ff      <= last.ray_y;
      end
   end

   function automatic logic [31:0] side_sat(input logic f_zero,
                                            input logic [31:0] delta,
                                            input logic [48:0] prod);
      if (f_zero) begin
         return '0;
      end else if (delta == '1 || prod[48]) begin
         return '1;
      end
      return prod[47:16];
   endfunction

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (advance) begin
         stage_valid_ff <= {last.valid, stage_valid_ff[3:0], req_valid};
         rsp_valid_ff   <= stage_valid_ff[5];
      end
   end

   // output register: hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ray_x           <= ray6_x_ff;
         rsp_ray_y           <= ray6_y_ff;
         rsp_cell_x          <= position_x_ff[23:16];
         rsp_cell_y          <= position_y_ff[23:16];
         rsp_step_x_negative <= ray6_x_ff[18];
         rsp_step_y_negative <= ray6_y_ff[18];
         rsp_delta_x         <= delta_x_ff;
         rsp_delta_y         <= delta_y_ff;
         rsp_side_x          <= side_sat(f_zero_x_ff, delta_x_ff, side_prod_x_ff);
         rsp_side_y          <= side_sat(f_zero_y_ff, delta_y_ff, side_prod_y_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The step sign always follows the delivered ray.
   a_step_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step_x_negative == rsp_ray_x[18]
                     && rsp_step_y_negative == rsp_ray_y[18]))
      else $error("step sign disagrees with ray");

   // |ray| never exceeds 2^18, so delta stays at or above 2^14.
   a_delta_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_delta_x >= 32'd16384 && rsp_delta_y >= 32'd16384))
      else $error("delta below reciprocal floor");

   // Input stalls only while a finished result is held.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // A request entering the pipeline shows up in the first stage next cycle.
   a_entry: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> stage_valid_ff[0])
      else $error("accepted request lost at entry");

endmodule
